FILE: sv/scnru_pkg.sv
// Shared constants and codes for the skewed-associative cache NRU core.
// Used by the core, the port checker and the testbench package; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scnru_pkg;

    // Default configuration of the tag store
    localparam int NUM_BANKS_DEF     = 4;
    localparam int SETS_PER_BANK_DEF = 1024;
    localparam int ADDR_BITS_DEF     = 32;

    // Fixed field widths of the stream beats
    localparam int ADDR_W     = 32;
    localparam int IDX_W      = 10;
    localparam int BANK_W     = 2;
    localparam int MAX_BANKS  = 4;
    localparam int EPOCH_W    = 32;
    localparam int LOG2_W     = 5;

    // Beat layout: input tdata is addr, start_bank, bank_index_0..3
    localparam int START_LSB  = ADDR_W;
    localparam int IDX_LSB    = ADDR_W + BANK_W;
    localparam int S_DATA_W   = 80;
    // Output tdata is hit, chosen_bank, victim_valid, victim_addr
    localparam int M_DATA_W   = 40;

    localparam logic [LOG2_W-1:0]  LOG2_SIZE_RST = 5'd12;
    localparam logic [EPOCH_W-1:0] EPOCH_ONES    = 32'hffff_ffff;

    // Request kinds carried in the input tuser
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_ALLOC  = 1'b1;

endpackage : scnru_pkg

`default_nettype wire

FILE: sv/scnru_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; width and depth come from parameters.
`timescale 1ns / 1ps
`default_nettype none

module scnru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_we,
    input  wire [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire [WIDTH-1:0]                 i_wdata,
    input  wire                             i_re,
    input  wire [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : scnru_ram

`default_nettype wire

FILE: sv/skewed_cache_nru_replacement_core.sv
// Tag and stamp store of a skewed-associative cache with NRU replacement.
// Depends on scnru_pkg and scnru_ram (one RAM per bank: valid, stamp, tag).
//
// Usage:
//   Slave stream (i_s_*): one request per beat. tuser is the request kind
//   (lookup with stamp update, or allocate after a miss); tdata carries the
//   line address, the victim-scan start bank and the set index per bank.
//   Master stream (o_m_*): one result per request: hit, chosen bank, and the
//   evicted address on an allocate.
//   Config: i_cfg_wr_en writes log2 of the cache size (sets the epoch
//   boundary); write it only while no request is in flight.
// Timing:
//   A request reads every bank at the accepting edge; the next cycle compares,
//   picks the bank, writes the entry back and loads the result register.
//   The result stream is driven from that register. No new request is taken
//   while one is evaluated, because of the read-modify-write of the bank RAMs.
// Reset:
//   After reset the core sweeps all SETS_PER_BANK rows to clear the valid
//   bits, one row per cycle, with o_s_tready low; config writes still land.
// Stall:
//   The result register holds until taken; a new request is accepted in the
//   cycle the pending result is taken or when the register is empty.
`timescale 1ns / 1ps
`default_nettype none

module skewed_cache_nru_replacement_core #(
    parameter int NUM_BANKS     = scnru_pkg::NUM_BANKS_DEF,
    parameter int SETS_PER_BANK = scnru_pkg::SETS_PER_BANK_DEF,
    parameter int ADDR_BITS     = scnru_pkg::ADDR_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // Config: log2_size
    input  wire                             i_cfg_wr_en,
    input  wire [scnru_pkg::LOG2_W-1:0]     i_cfg_wr_data,
    // Request stream
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    // tdata: addr[31:0], start_bank[33:32], bank_index_0..3 [43:34]..[73:64], zero
    input  wire [scnru_pkg::S_DATA_W-1:0]   i_s_tdata,
    // tuser: req_type[0]
    input  wire                             i_s_tuser,
    // Result stream
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    // tdata: hit[0], chosen_bank[2:1], victim_valid[3], victim_addr[35:4], zero
    output logic [scnru_pkg::M_DATA_W-1:0]  o_m_tdata
);

    import scnru_pkg::*;

    localparam int SET_W   = $clog2(SETS_PER_BANK);
    localparam int BW      = $clog2(NUM_BANKS);
    localparam int WORD_W  = 1 + EPOCH_W + ADDR_BITS;
    localparam int IDX_SPAN = 1 << IDX_W;
    // Reciprocal for reducing a set index below a small bank size
    localparam int RECIP_SH = 2 * IDX_W;
    localparam int RECIP    = (1 << RECIP_SH) / SETS_PER_BANK;
    localparam int RECIP_W  = $clog2(RECIP + 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [SET_W-1:0]       r_clr, n_clr;
    logic [LOG2_W-1:0]      r_log2;
    logic [EPOCH_W-1:0]     r_epoch, n_epoch;
    logic                   r_req;
    logic [ADDR_BITS-1:0]   r_addr;
    logic [BW-1:0]          r_start;
    logic [SET_W-1:0]       r_idx [NUM_BANKS];
    logic                   r_m_valid, n_m_valid;
    logic [M_DATA_W-1:0]    r_m_data, n_m_data;

    logic                   w_s_acc;
    logic [SET_W-1:0]       w_idx [NUM_BANKS];
    logic [BW-1:0]          w_start;
    logic [WORD_W-1:0]      w_rd [NUM_BANKS];
    logic                   w_vld [NUM_BANKS];
    logic [EPOCH_W-1:0]     w_stamp [NUM_BANKS];
    logic [ADDR_BITS-1:0]   w_tag [NUM_BANKS];
    logic                   w_we [NUM_BANKS];
    logic [SET_W-1:0]       w_waddr [NUM_BANKS];
    logic [WORD_W-1:0]      w_wdata;

    logic [EPOCH_W-1:0]     w_bound;
    logic                   w_hit;
    logic [BW-1:0]          w_hit_bank;
    logic [BW:0]            w_bk_sum;
    logic [BW-1:0]          w_bk;
    logic [BW-1:0]          w_alloc_bank;
    logic [BW-1:0]          w_sel;
    logic                   w_do_wr;
    logic [EPOCH_W-1:0]     w_new_stamp;
    logic                   w_eval;

    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == ST_IDLE) && (!r_m_valid || i_m_tready);
    assign w_eval     = (r_state == ST_EVAL);

    // Reduce the start bank below the bank count
    always_comb begin
        if ({1'b0, i_s_tdata[START_LSB +: BANK_W]} >= (BANK_W+1)'(NUM_BANKS)) begin
            w_start = BW'(i_s_tdata[START_LSB +: BANK_W] - BANK_W'(NUM_BANKS));
        end else begin
            w_start = BW'(i_s_tdata[START_LSB +: BANK_W]);
        end
    end

    // Per-bank set index, reduction and RAM
    for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
        logic [IDX_W-1:0] w_raw;
        assign w_raw = i_s_tdata[IDX_LSB + b*IDX_W +: IDX_W];

        if (SETS_PER_BANK >= IDX_SPAN) begin : g_wide
            assign w_idx[b] = SET_W'(w_raw);
        end else begin : g_mod
            localparam logic [IDX_W:0] SETS_L = (IDX_W+1)'(SETS_PER_BANK);
            logic [IDX_W+RECIP_W-1:0] w_prod;
            logic [IDX_W-1:0]         w_q;
            logic [2*IDX_W+1:0]       w_qs;
            logic [IDX_W:0]           w_rem;
            // Quotient may fall one short; one compare-subtract corrects it
            assign w_prod = (IDX_W+RECIP_W)'(w_raw) * (IDX_W+RECIP_W)'(RECIP);
            assign w_q    = IDX_W'(w_prod >> RECIP_SH);
            assign w_qs   = w_q * SETS_L;
            assign w_rem  = {1'b0, w_raw} - w_qs[IDX_W:0];
            assign w_idx[b] = (w_rem >= SETS_L) ? SET_W'(w_rem - SETS_L) : SET_W'(w_rem);
        end

        scnru_ram #(
            .WIDTH (WORD_W),
            .DEPTH (SETS_PER_BANK)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[b]),
            .i_waddr (w_waddr[b]),
            .i_wdata (w_wdata),
            .i_re    (w_s_acc),
            .i_raddr (w_idx[b]),
            .o_rdata (w_rd[b])
        );

        assign w_vld[b]   = w_rd[b][WORD_W-1];
        assign w_stamp[b] = w_rd[b][ADDR_BITS +: EPOCH_W];
        assign w_tag[b]   = w_rd[b][ADDR_BITS-1:0];

        // Clear sweep writes every bank; an allocate or a lookup hit writes the chosen bank
        assign w_we[b]    = (r_state == ST_CLEAR) || (w_eval && w_do_wr && (w_sel == BW'(b)));
        assign w_waddr[b] = (r_state == ST_CLEAR) ? r_clr : r_idx[b];
    end

    // Epoch boundary: clear the low log2_size-1 bits
    assign w_bound = (r_log2 == '0) ? '0 : (r_epoch & (EPOCH_ONES << (r_log2 - LOG2_W'(1))));

    // Compare banks, pick victim, form write-back and result
    always_comb begin
        w_hit      = 1'b0;
        w_hit_bank = '0;
        for (int b = NUM_BANKS - 1; b >= 0; b--) begin
            if (w_vld[b] && (w_tag[b] == r_addr)) begin
                w_hit      = 1'b1;
                w_hit_bank = BW'(b);
            end
        end

        // Old line scan from the start bank with wrap, last one wins
        w_alloc_bank = r_start;
        w_bk_sum     = '0;
        w_bk         = '0;
        for (int k = 0; k < NUM_BANKS; k++) begin
            w_bk_sum = {1'b0, r_start} + (BW+1)'(k);
            if (w_bk_sum >= (BW+1)'(NUM_BANKS)) begin
                w_bk = BW'(w_bk_sum - (BW+1)'(NUM_BANKS));
            end else begin
                w_bk = BW'(w_bk_sum);
            end
            if (w_stamp[w_bk] < w_bound) begin
                w_alloc_bank = w_bk;
            end
        end
        // A free entry beats any old line; highest free bank wins
        for (int b = 0; b < NUM_BANKS; b++) begin
            if (!w_vld[b]) begin
                w_alloc_bank = BW'(b);
            end
        end

        n_m_data = '0;
        if (r_req == REQ_ALLOC) begin
            w_sel       = w_alloc_bank;
            w_do_wr     = 1'b1;
            w_new_stamp = r_epoch;
            n_epoch     = r_epoch + EPOCH_W'(1);
            n_m_data[2:1] = BANK_W'(w_alloc_bank);
            if (w_vld[w_alloc_bank]) begin
                n_m_data[3]    = 1'b1;
                n_m_data[35:4] = ADDR_W'(w_tag[w_alloc_bank]);
            end
        end else begin
            w_sel   = w_hit_bank;
            w_do_wr = w_hit;
            if (w_hit && (w_stamp[w_hit_bank] < w_bound)) begin
                n_epoch = r_epoch + EPOCH_W'(1);
            end else begin
                n_epoch = r_epoch;
            end
            w_new_stamp   = n_epoch;
            n_m_data[0]   = w_hit;
            n_m_data[2:1] = BANK_W'(w_hit_bank);
        end

        if (r_state == ST_CLEAR) begin
            w_wdata = '0;
        end else begin
            w_wdata = {1'b1, w_new_stamp, r_addr};
        end
    end

    // Sequencer: clear sweep, wait for a request, evaluate it
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + SET_W'(1);
                if (r_clr == SET_W'(SETS_PER_BANK - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Result register: load on evaluate, drop when taken
    always_comb begin
        n_m_valid = r_m_valid;
        if (w_eval) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_log2    <= LOG2_SIZE_RST;
            r_epoch   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_m_valid <= n_m_valid;
            if (i_cfg_wr_en) begin
                r_log2 <= i_cfg_wr_data;
            end
            if (w_eval) begin
                r_epoch <= n_epoch;
            end
        end
    end

    // Hold request fields for the evaluate cycle
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_req   <= i_s_tuser;
            r_addr  <= i_s_tdata[ADDR_BITS-1:0];
            r_start <= w_start;
            r_idx   <= w_idx;
        end
        if (w_eval) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule : skewed_cache_nru_replacement_core

`default_nettype wire

FILE: sv/scnru_checker.sv
// Port-level checker for the skewed-associative cache NRU core, with bind.
// Depends on scnru_pkg; sees only the top-level ports.
`timescale 1ns / 1ps
`default_nettype none

module scnru_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    input  wire                             o_s_tready,
    input  wire                             o_m_tvalid,
    input  wire                             i_m_tready,
    input  wire [scnru_pkg::M_DATA_W-1:0]   o_m_tdata
);

    logic w_s_acc;
    assign w_s_acc = i_s_tvalid && o_s_tready;

    // One request at a time: no beat right after an accepted one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !o_s_tready)
        else $error("request accepted back to back");

    // Result is valid once the evaluate cycle has passed
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |-> ##2 o_m_tvalid)
        else $error("result missing after accepted request");

    // A result only follows an accepted request
    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_s_acc, 2))
        else $error("result without a request");

    // A hit never reports an eviction
    a_hit_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> !o_m_tdata[3])
        else $error("hit beat carries a victim");

    // Stalled result beat holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result beat changed");

endmodule : scnru_checker

bind skewed_cache_nru_replacement_core scnru_checker u_scnru_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

FILE: verif/scnru_tb_pkg.sv
// Request and result types plus the scoreboard for the skewed-cache NRU core.
// The scoreboard keeps its own tags, stamps, valid bits and epoch counter.
// Depends on scnru_pkg for field widths, reset values and request kinds.
`timescale 1ns / 1ps

package scnru_tb_pkg;
    import scnru_pkg::*;

    localparam int BANKS = NUM_BANKS_DEF;
    localparam int ROWS  = SETS_PER_BANK_DEF;

    typedef logic [MAX_BANKS-1:0][IDX_W-1:0] t_rowset;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] addr;
        logic [BANK_W-1:0] start;
        t_rowset           row;
    } t_request;

    typedef struct packed {
        logic              hit;
        logic [BANK_W-1:0] bank;
        logic              victim_valid;
        logic [ADDR_W-1:0] victim_addr;
    } t_result;

    class nru_scoreboard;
        bit [ADDR_W-1:0]  tags   [BANKS][ROWS];
        bit [EPOCH_W-1:0] stamps [BANKS][ROWS];
        bit               valid  [BANKS][ROWS];
        bit [EPOCH_W-1:0] epoch;
        bit [LOG2_W-1:0]  log2_size;
        t_result          outcome_q[$];
        t_result          last;
        int               errors;

        function new();
            epoch     = '0;
            log2_size = LOG2_SIZE_RST;
            errors    = 0;
            last      = '0;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void set_size(bit [LOG2_W-1:0] v);
            log2_size = v;
        endfunction

        // Print one line per mismatch and count it
        function void report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // Epoch counter with its low log2_size-1 bits cleared
        function bit [EPOCH_W-1:0] epoch_floor();
            bit [EPOCH_W-1:0] low_mask;
            if (log2_size == 0)
                return '0;
            low_mask = (EPOCH_W'(1) << (log2_size - 1)) - 1;
            return epoch & ~low_mask;
        endfunction

        // Apply one accepted request to the cache image and queue its outcome
        function void note_request(t_request rq);
            t_result r;
            int      b, k, bk, pick, sel [BANKS];
            bit      found;
            bit [EPOCH_W-1:0] floor_v;
            r = '0;
            found = 1'b0;
            for (b = 0; b < BANKS; b++)
                sel[b] = int'(rq.row[b]) % ROWS;
            if (rq.req_type == REQ_LOOKUP) begin
                // Lowest matching bank wins; an aged stamp bumps the epoch first
                for (b = 0; b < BANKS; b++) begin
                    if (!found && valid[b][sel[b]] && tags[b][sel[b]] == rq.addr) begin
                        found = 1'b1;
                        if (stamps[b][sel[b]] < epoch_floor())
                            epoch++;
                        stamps[b][sel[b]] = epoch;
                        r.hit  = 1'b1;
                        r.bank = BANK_W'(b);
                    end
                end
            end else begin
                // Start bank, then last aged line in scan order, then highest free
                floor_v = epoch_floor();
                pick = int'(rq.start) % BANKS;
                for (k = 0; k < BANKS; k++) begin
                    bk = (int'(rq.start) + k) % BANKS;
                    if (stamps[bk][sel[bk]] < floor_v)
                        pick = bk;
                end
                for (b = 0; b < BANKS; b++)
                    if (!valid[b][sel[b]])
                        pick = b;
                if (valid[pick][sel[pick]]) begin
                    r.victim_valid = 1'b1;
                    r.victim_addr  = tags[pick][sel[pick]];
                end
                stamps[pick][sel[pick]] = epoch;
                epoch++;
                tags[pick][sel[pick]]  = rq.addr;
                valid[pick][sel[pick]] = 1'b1;
                r.bank = BANK_W'(pick);
            end
            outcome_q.push_back(r);
            last = r;
        endfunction

        // Compare one result beat with the oldest outcome, field by field
        function void check_result(logic [M_DATA_W-1:0] data);
            t_result want;
            if (outcome_q.size() == 0) begin
                report($sformatf("result beat 0x%h with no request outstanding", data));
                return;
            end
            want = outcome_q.pop_front();
            if (data[0] !== want.hit)
                report($sformatf("hit got %b want %b", data[0], want.hit));
            if (data[2:1] !== want.bank)
                report($sformatf("chosen_bank got %0d want %0d", data[2:1], want.bank));
            if (data[3] !== want.victim_valid)
                report($sformatf("victim_valid got %b want %b", data[3], want.victim_valid));
            if (data[35:4] !== want.victim_addr)
                report($sformatf("victim_addr got 0x%h want 0x%h", data[35:4],
                                 want.victim_addr));
        endfunction
    endclass

endpackage : scnru_tb_pkg

FILE: verif/testbench.sv
// Top-level testbench of skewed_cache_nru_replacement_core: directed and
// pool-based random cache requests under random stalls on both streams.
// Depends on scnru_pkg, scnru_tb_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import scnru_pkg::*;
    import scnru_tb_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 125;
    localparam int PHASES       = 10;
    localparam int POOL_SIZE    = 32;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [LOG2_W-1:0]   i_cfg_wr_data = '0;
    logic                i_s_tvalid    = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata     = '0;
    logic                i_s_tuser     = 1'b0;
    logic                o_m_tvalid;
    logic                i_m_tready    = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;

    nru_scoreboard sb = new();

    bit                calm     = 1'b0;
    bit                quiet    = 1'b0;
    bit                hold_req = 1'b0;
    int                window_base = 0;
    int                follow_slot = -1;
    int                cur_slot    = -1;
    logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
    t_rowset           pool_row  [POOL_SIZE];

    skewed_cache_nru_replacement_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    // 8 ns clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Cycle limit
    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < LIMIT_CYCLES; cycles++)
            @(posedge i_clk);
        $display("skewed_cache_nru_replacement_core regression: fail");
        $finish;
    end

    // Check every result beat taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    // Result sink: stall bursts, ready stretches, one long hold-off on request
    initial begin : result_sink
        int n;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(posedge i_clk);
            end else if (calm) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    function automatic t_rowset rows4(int r0, int r1, int r2, int r3);
        t_rowset rs;
        rs[0] = IDX_W'(r0);
        rs[1] = IDX_W'(r1);
        rs[2] = IDX_W'(r2);
        rs[3] = IDX_W'(r3);
        return rs;
    endfunction

    function automatic t_request make_req(logic kind, logic [ADDR_W-1:0] addr, int start,
                                          t_rowset rs);
        t_request rq;
        rq.req_type = kind;
        rq.addr     = addr;
        rq.start    = BANK_W'(start);
        rq.row      = rs;
        return rq;
    endfunction

    // Give a pool slot a new address and set indexes inside the current window
    function automatic void fill_slot(int j);
        int b;
        pool_addr[j] = $urandom;
        for (b = 0; b < MAX_BANKS; b++)
            pool_row[j][b] = IDX_W'(window_base + $urandom_range(0, 7));
    endfunction

    // Miss followed by allocate, pool lookups and allocates, and some noise
    function automatic t_request next_item();
        int      r, j, b;
        t_rowset rs;
        cur_slot = -1;
        if (follow_slot >= 0) begin
            j = follow_slot;
            follow_slot = -1;
            cur_slot = j;
            return make_req(REQ_ALLOC, pool_addr[j], $urandom_range(0, 3), pool_row[j]);
        end
        r = $urandom_range(0, 99);
        if (r < 80) begin
            j = $urandom_range(0, POOL_SIZE - 1);
            cur_slot = j;
            return make_req(r < 65 ? REQ_LOOKUP : REQ_ALLOC, pool_addr[j],
                            $urandom_range(0, 3), pool_row[j]);
        end
        for (b = 0; b < MAX_BANKS; b++)
            rs[b] = IDX_W'($urandom);
        return make_req(logic'($urandom_range(0, 1)), $urandom, $urandom_range(0, 3), rs);
    endfunction

    function automatic int phase_size(int ph);
        case (ph)
            0:       return 1;
            1:       return 2;
            2:       return 3;
            3:       return 31;
            4:       return 4;
            5:       return 0;
            6:       return $urandom_range(6, 30);
            7:       return 1;
            8:       return 5;
            default: return 2;
        endcase
    endfunction

    // Drop tvalid and idle for as long as the argument n asks
    task automatic idle_tx(int n);
        i_s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Offer one request beat and hold it until accepted
    task automatic send_request(t_request rq);
        logic [S_DATA_W-1:0] beat;
        int b;
        beat = '0;
        beat[ADDR_W-1:0] = rq.addr;
        beat[START_LSB +: BANK_W] = rq.start;
        for (b = 0; b < MAX_BANKS; b++)
            beat[IDX_LSB + b*IDX_W +: IDX_W] = rq.row[b];
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= beat;
        i_s_tuser  <= rq.req_type;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.note_request(rq);
    endtask

    task automatic offer(t_request rq);
        if (!calm && !quiet && $urandom_range(0, 3) == 0)
            idle_tx($urandom_range(1, 14));
        send_request(rq);
    endtask

    // Wait for every outstanding result, then write log2_size
    task automatic retune(int v);
        idle_tx(0);
        while (sb.pending() != 0)
            @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= LOG2_W'(v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_size(LOG2_W'(v));
    endtask

    initial begin : stimulus
        int       ph, n, j;
        t_request rq;
        t_rowset  r5, rtop, rmix, rzero;
        r5    = rows4(5, 5, 5, 5);
        rtop  = rows4(1023, 1023, 1023, 1023);
        rmix  = rows4(0, 1023, 0, 1023);
        rzero = rows4(0, 0, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill one set group at reset size: free entries go highest bank first
        offer(make_req(REQ_LOOKUP, 32'h0000_0000, 0, r5));
        offer(make_req(REQ_ALLOC,  32'h0000_0000, 0, r5));
        offer(make_req(REQ_LOOKUP, 32'h0000_0000, 0, r5));
        offer(make_req(REQ_ALLOC,  32'hffff_ffff, 1, r5));
        offer(make_req(REQ_ALLOC,  32'h1234_5678, 2, r5));
        offer(make_req(REQ_ALLOC,  32'h9abc_def0, 3, r5));
        offer(make_req(REQ_LOOKUP, 32'hffff_ffff, 0, r5));
        // Second copy of an address; lookup reports the lowest bank
        offer(make_req(REQ_ALLOC,  32'hffff_ffff, 3, rtop));
        offer(make_req(REQ_LOOKUP, 32'hffff_ffff, 0, rows4(5, 5, 5, 1023)));
        // Full set, nothing aged: the start bank is replaced
        offer(make_req(REQ_ALLOC,  32'ha5a5_a5a5, 2, r5));

        // Smallest size: every line not touched this epoch is aged
        retune(1);
        offer(make_req(REQ_ALLOC,  32'h5a5a_5a5a, 1, r5));
        offer(make_req(REQ_LOOKUP, 32'h0000_0000, 2, r5));
        offer(make_req(REQ_LOOKUP, 32'h0000_0000, 3, r5));
        offer(make_req(REQ_ALLOC,  32'hc3c3_c3c3, 0, r5));

        // Zero size: nothing ever aged
        retune(0);
        offer(make_req(REQ_ALLOC,  32'h0f0f_0f0f, 3, r5));
        offer(make_req(REQ_LOOKUP, 32'h8000_0000, 1, rzero));

        // Largest size, partly filled set picks the highest free bank
        retune(31);
        offer(make_req(REQ_ALLOC,  32'h8000_0000, 0, rmix));
        offer(make_req(REQ_LOOKUP, 32'h8000_0000, 0, rmix));
        offer(make_req(REQ_ALLOC,  32'h1111_1111, 3, rmix));
        offer(make_req(REQ_LOOKUP, 32'h1111_1111, 3, rmix));
        retune(30);
        offer(make_req(REQ_LOOKUP, 32'h0000_0001, 2, rtop));

        // Random phases, one size each; long sink hold-off in the third
        for (ph = 0; ph < PHASES; ph++) begin
            retune(phase_size(ph));
            calm = (ph == PHASES - 1);
            if (ph == 2)
                hold_req = 1'b1;
            case (ph % 3)
                0:       window_base = 0;
                1:       window_base = 1016;
                default: window_base = $urandom_range(0, 1016);
            endcase
            for (j = 0; j < POOL_SIZE; j++)
                fill_slot(j);
            follow_slot = -1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 19) == 0)
                    fill_slot($urandom_range(0, POOL_SIZE - 1));
                rq = next_item();
                offer(rq);
                if (rq.req_type == REQ_LOOKUP && cur_slot >= 0 && !sb.last.hit &&
                    $urandom_range(0, 99) < 85)
                    follow_slot = cur_slot;
            end
        end

        // Drain and settle
        idle_tx(0);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("skewed_cache_nru_replacement_core regression: pass");
        else
            $display("skewed_cache_nru_replacement_core regression: fail");
        $finish;
    end

endmodule : testbench
